@@ rtl/core/tea_pkg.sv @@
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types and codes for the triggered epoch averager.
// ----------------------------------------------------------------------------
`default_nettype none

package tea_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_ACC,
        ST_RDWAIT,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        REQ_SAMPLE  = 2'd0,
        REQ_TRIGGER = 2'd1,
        REQ_READ    = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    localparam logic [3:0] CFG_PRE_SAMPLES = 4'd0;
    localparam logic [3:0] CFG_CAPTURE_LEN = 4'd1;
    localparam logic [3:0] CFG_AVG_WINDOW  = 4'd2;
    localparam logic [3:0] CFG_AVG_LIMIT   = 4'd3;

    localparam logic [11:0] PRE_RESET     = 12'd96;
    localparam logic [15:0] CAPTURE_RESET = 16'd960;
    localparam logic [10:0] WINDOW_RESET  = 11'd960;
    localparam logic [7:0]  LIMIT_RESET   = 8'd50;

endpackage

`default_nettype wire

@@ rtl/core/tea_ram.sv @@
// ----------------------------------------------------------------------------
// tea_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/triggered_epoch_averager.sv @@
// ----------------------------------------------------------------------------
// triggered_epoch_averager
// Triggered signal averaging with a pre-trigger window over a sample ring.
// ----------------------------------------------------------------------------
// Usage:
//  Input words (valid/ready) are samples, triggers, reads or no-op words;
//  each gives one result word on the output channel (valid/ready). Config
//  writes use their own channel, always ready; the user must see that they
//  are issued only while the block is idle, as the block does not enforce it.
//  A sample or trigger scans the pending queue one slot per cycle, newest
//  first, pausing while a beat accumulates; each completed beat streams
//  min(avg_window, SUM_DEPTH) samples through the ring RAM and the sum RAM,
//  one per cycle.
//  Reset, and every avg_window write, starts a clearing pass over the sum
//  RAM, during which no input word is taken.
//  The result sits in an output register; the next word is accepted while
//  it waits, and that word's result holds in the core until the output
//  register is taken by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module triggered_epoch_averager #(
    parameter int RING_DEPTH    = 65536,
    parameter int PENDING_SLOTS = 4,
    parameter int SUM_DEPTH     = 1024,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [1:0]               i_req_type,
    input  wire logic [SAMPLE_BITS-1:0]   i_sample_value,
    input  wire logic [31:0]              i_event_pos,
    input  wire logic                     i_has_class,
    input  wire logic                     i_given_is_tic,
    input  wire logic [9:0]               i_read_index,
    input  wire logic                     i_read_tic,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [SAMPLE_BITS+6:0]        o_avg_sum,
    output logic [7:0]                    o_avg_count,
    output logic [2:0]                    o_beats_done,
    output logic [2:0]                    o_beats_dropped,
    output logic                          o_cycle_complete,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [3:0]               i_cfg_index,
    input  wire logic [31:0]              i_cfg_data
);
    import tea_pkg::*;

    localparam int MAG_W  = SAMPLE_BITS - 1;
    localparam int SUM_W  = SAMPLE_BITS + 7;
    localparam int RAW    = $clog2(RING_DEPTH);
    localparam int FW     = $clog2(RING_DEPTH + 1);
    localparam int SAW    = $clog2(SUM_DEPTH);
    localparam int LEN_W  = $clog2(SUM_DEPTH + 1);
    localparam int IW     = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int CW     = $clog2(PENDING_SLOTS + 1);

    t_state r_state, n_state;

    logic [11:0]     r_pre;
    logic [15:0]     r_capture;
    logic [10:0]     r_window;
    logic [7:0]      r_limit;
    logic [RAW-1:0]  r_wr;
    logic [FW-1:0]   r_fill;
    logic [31:0]     r_total;
    logic [31:0]     r_pos [PENDING_SLOTS];
    logic            r_cls [PENDING_SLOTS];
    logic [CW-1:0]   r_cnt;
    logic            r_parity;
    logic [7:0]      r_tic_beats, r_toc_beats;
    logic [IW-1:0]   r_idx;
    logic [SAW:0]    r_clr;
    logic [RAW-1:0]  r_raddr;
    logic [LEN_W-1:0] r_k, r_len;
    logic            r_acls;
    logic            r_p1;
    logic [SAW-1:0]  r_p1k;
    logic [2:0]      r_done, r_drop;
    logic [SUM_W-1:0] r_res_sum;
    logic [7:0]      r_res_cnt;
    logic            r_rd_ok;
    logic            r_is_read;

    logic             ring_we;
    logic [MAG_W-1:0] ring_rdata;
    logic             sum_we;
    logic [SAW:0]     sum_waddr, sum_raddr;
    logic [SUM_W-1:0] sum_wdata, sum_rdata;

    logic             in_acc, out_load, cfg_wr, win_wr;
    logic [SAMPLE_BITS-1:0] neg_v;
    logic [MAG_W-1:0] mag;
    logic [31:0]      slot_pos, start, back;
    logic             slot_cls, c_ahead, c_gone, c_short, cls_full, remove, acc_end;
    logic [15:0]      need;
    logic [LEN_W-1:0] acc_len;
    logic [RAW+1:0]   base_sum;
    logic [RAW-1:0]   base;

    assign in_acc   = i_valid && o_ready;
    assign out_load = (r_state == ST_FINISH) && (!o_valid || i_ready);
    assign cfg_wr   = i_cfg_valid && o_cfg_ready;
    assign win_wr   = cfg_wr && (i_cfg_index == CFG_AVG_WINDOW);
    assign o_cfg_ready = 1'b1;

    // sample magnitude, saturated
    assign neg_v = -i_sample_value;
    always_comb begin
        if (!i_sample_value[SAMPLE_BITS-1]) begin
            mag = i_sample_value[MAG_W-1:0];
        end else if (neg_v[SAMPLE_BITS-1]) begin
            mag = '1;
        end else begin
            mag = neg_v[MAG_W-1:0];
        end
    end

    assign slot_pos = r_pos[r_idx];
    assign slot_cls = r_cls[r_idx];
    assign start    = slot_pos - 32'(r_pre);
    assign back     = r_total - start;
    assign need     = (r_capture > 16'(r_window)) ? r_capture : 16'(r_window);
    assign c_ahead  = back[31];
    assign c_gone   = back > 32'(r_fill);
    assign c_short  = back < 32'(need);
    assign cls_full = slot_cls ? (r_tic_beats >= r_limit) : (r_toc_beats >= r_limit);
    assign acc_len  = (32'(r_window) < SUM_DEPTH) ? LEN_W'(r_window) : LEN_W'(SUM_DEPTH);
    assign base_sum = (RAW+2)'(r_wr) + (RAW+2)'(RING_DEPTH) - back[RAW+1:0];
    assign base     = (base_sum >= (RAW+2)'(RING_DEPTH))
                    ? RAW'(base_sum - (RAW+2)'(RING_DEPTH)) : RAW'(base_sum);
    assign acc_end  = (r_state == ST_ACC) && (r_k == r_len) && !r_p1;
    assign remove   = ((r_state == ST_SCAN) && !c_ahead && (c_gone || (!c_short && cls_full)))
                    || acc_end;

    // FSM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (t_req'(i_req_type))
                        REQ_SAMPLE:  n_state = (r_cnt != '0) ? ST_SCAN : ST_FINISH;
                        REQ_TRIGGER: n_state = ST_SCAN;
                        REQ_READ:    n_state = ST_RDWAIT;
                        REQ_NONE:    n_state = ST_FINISH;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (r_clr == (SAW+1)'(2 * SUM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!c_ahead && !c_gone && !c_short && !cls_full) begin
                    n_state = ST_ACC;
                end else if (r_idx == '0) begin
                    n_state = ST_FINISH;
                end
            end
            ST_ACC: begin
                if (acc_end) begin
                    n_state = (r_idx == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_RDWAIT: n_state = ST_FINISH;
            ST_FINISH: begin
                if (!o_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (win_wr) begin
            n_state = ST_CLEAR;
        end
    end

    // RAM ports
    assign ring_we   = in_acc && (t_req'(i_req_type) == REQ_SAMPLE);
    assign sum_raddr = (r_state == ST_ACC) ? {r_acls, r_k[SAW-1:0]}
                                           : {i_read_tic, SAW'(i_read_index)};
    always_comb begin
        if (r_state == ST_CLEAR) begin
            sum_we    = 1'b1;
            sum_waddr = r_clr;
            sum_wdata = '0;
        end else begin
            sum_we    = r_p1;
            sum_waddr = {r_acls, r_p1k};
            sum_wdata = sum_rdata + SUM_W'(ring_rdata);
        end
    end

    tea_ram #(.WIDTH(MAG_W), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wr),
        .i_wdata (mag),
        .i_raddr (r_raddr),
        .o_rdata (ring_rdata)
    );

    tea_ram #(.WIDTH(SUM_W), .DEPTH(2 * SUM_DEPTH)) u_sums (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre       <= PRE_RESET;
            r_capture   <= CAPTURE_RESET;
            r_window    <= WINDOW_RESET;
            r_limit     <= LIMIT_RESET;
            r_wr        <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_cnt       <= '0;
            r_parity    <= 1'b0;
            r_tic_beats <= '0;
            r_toc_beats <= '0;
            r_clr       <= '0;
            r_p1        <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_PRE_SAMPLES: r_pre     <= i_cfg_data[11:0];
                    CFG_CAPTURE_LEN: r_capture <= i_cfg_data[15:0];
                    CFG_AVG_WINDOW: begin
                        r_window    <= i_cfg_data[10:0];
                        r_tic_beats <= '0;
                        r_toc_beats <= '0;
                    end
                    CFG_AVG_LIMIT:   r_limit   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (win_wr) begin
                r_clr <= '0;
            end else if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end

            if (in_acc) begin
                r_done    <= '0;
                r_drop    <= '0;
                r_res_sum <= '0;
                r_res_cnt <= '0;
                r_is_read <= 1'b0;
                unique case (t_req'(i_req_type))
                    REQ_SAMPLE: begin
                        r_wr <= (r_wr == RAW'(RING_DEPTH - 1)) ? '0 : r_wr + 1'b1;
                        if (r_fill != FW'(RING_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_total <= r_total + 32'd1;
                        r_idx   <= IW'(r_cnt - 1'b1);
                    end
                    REQ_TRIGGER: begin
                        r_parity <= ~r_parity;
                        if (r_cnt == CW'(PENDING_SLOTS)) begin
                            for (int j = 0; j < PENDING_SLOTS - 1; j++) begin
                                r_pos[j] <= r_pos[j+1];
                                r_cls[j] <= r_cls[j+1];
                            end
                            r_pos[PENDING_SLOTS-1] <= i_event_pos;
                            r_cls[PENDING_SLOTS-1] <= i_has_class ? i_given_is_tic : !r_parity;
                            r_idx  <= IW'(PENDING_SLOTS - 1);
                            r_drop <= 3'd1;
                        end else begin
                            r_pos[IW'(r_cnt)] <= i_event_pos;
                            r_cls[IW'(r_cnt)] <= i_has_class ? i_given_is_tic : !r_parity;
                            r_idx <= IW'(r_cnt);
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    REQ_READ: begin
                        r_is_read <= 1'b1;
                        r_rd_ok   <= 32'(i_read_index) < SUM_DEPTH;
                        r_res_cnt <= i_read_tic ? r_tic_beats : r_toc_beats;
                    end
                    REQ_NONE: ;
                endcase
            end

            if (r_state == ST_RDWAIT && r_is_read && r_rd_ok) begin
                r_res_sum <= sum_rdata;
            end

            if (r_state == ST_SCAN) begin
                if (!c_ahead && !c_gone && !c_short && !cls_full) begin
                    r_raddr <= base;
                    r_k     <= '0;
                    r_len   <= acc_len;
                    r_acls  <= slot_cls;
                end else begin
                    if (!c_ahead && c_gone && r_drop != 3'd7) begin
                        r_drop <= r_drop + 1'b1;
                    end
                    if (!c_ahead && !c_gone && !c_short && r_done != 3'd7) begin
                        r_done <= r_done + 1'b1;
                    end
                    if (r_idx != '0) begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
            end

            if (r_state == ST_ACC) begin
                if (r_k != r_len) begin
                    r_p1    <= 1'b1;
                    r_p1k   <= r_k[SAW-1:0];
                    r_k     <= r_k + 1'b1;
                    r_raddr <= (r_raddr == RAW'(RING_DEPTH - 1)) ? '0 : r_raddr + 1'b1;
                end else begin
                    r_p1 <= 1'b0;
                end
                if (acc_end) begin
                    if (r_acls) begin
                        r_tic_beats <= r_tic_beats + 1'b1;
                    end else begin
                        r_toc_beats <= r_toc_beats + 1'b1;
                    end
                    if (r_done != 3'd7) begin
                        r_done <= r_done + 1'b1;
                    end
                    if (r_idx != '0) begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
            end

            if (remove) begin
                for (int j = 0; j < PENDING_SLOTS - 1; j++) begin
                    if (j >= int'(r_idx) && j + 1 < int'(r_cnt)) begin
                        r_pos[j] <= r_pos[j+1];
                        r_cls[j] <= r_cls[j+1];
                    end
                end
                r_cnt <= r_cnt - 1'b1;
            end

            if (out_load) begin
                o_valid          <= 1'b1;
                o_avg_sum        <= r_res_sum;
                o_avg_count      <= r_res_cnt;
                o_beats_done     <= r_done;
                o_beats_dropped  <= r_drop;
                o_cycle_complete <= (r_tic_beats >= r_limit) && (r_toc_beats >= r_limit);
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(PENDING_SLOTS))
        else $error("pending count above slot count");

    a_pipe_in_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1 |-> (r_state == ST_ACC))
        else $error("sum pipeline active outside accumulation");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_ready)
        else $error("input word taken during clearing pass");
`endif

endmodule

`default_nettype wire

@@ tb/tea_checker.sv @@
// ----------------------------------------------------------------------------
// tea_checker
// Watches the input, result and config channels of the averager. It keeps
// its own copy of the ring, pending queue and sum arrays, predicts one result
// word per accepted input word and compares it with the actual result word.
// ----------------------------------------------------------------------------
module tea_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_sample_value,
    input  logic [31:0] i_event_pos,
    input  logic        i_has_class,
    input  logic        i_given_is_tic,
    input  logic [9:0]  i_read_index,
    input  logic        i_read_tic,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [22:0] o_avg_sum,
    input  logic [7:0]  o_avg_count,
    input  logic [2:0]  o_beats_done,
    input  logic [2:0]  o_beats_dropped,
    input  logic        o_cycle_complete,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_outstanding
);
    import tea_pkg::*;

    typedef struct packed {
        logic [22:0] sum;
        logic [7:0]  count;
        logic [2:0]  done;
        logic [2:0]  dropped;
        logic        complete;
    } t_result;

    t_result     result_q[$];
    int          mismatches;

    logic [11:0] pre_samples;
    logic [15:0] capture_len;
    logic [10:0] avg_window;
    logic [7:0]  avg_limit;

    logic [14:0] ring[65536];
    logic [15:0] wr_ptr;
    logic [31:0] fill_level;
    logic [31:0] sample_count;
    logic [31:0] trig_pos[4];
    logic        trig_tic[4];
    int          trig_n;
    logic        parity;
    logic [22:0] tic_sum[1024];
    logic [22:0] toc_sum[1024];
    logic [7:0]  tic_beats;
    logic [7:0]  toc_beats;

    task automatic clear_sums();
        for (int k = 0; k < 1024; k++) begin
            tic_sum[k] = '0;
            toc_sum[k] = '0;
        end
        tic_beats = '0;
        toc_beats = '0;
    endtask

    task automatic drop_trigger(input int slot);
        for (int j = slot; j + 1 < trig_n; j++) begin
            trig_pos[j] = trig_pos[j + 1];
            trig_tic[j] = trig_tic[j + 1];
        end
        trig_n--;
    endtask

    task automatic add_epoch(input logic is_tic, input logic [31:0] back);
        int          len;
        logic [15:0] idx;
        len = (avg_window < 1024) ? int'(avg_window) : 1024;
        if (is_tic ? (tic_beats >= avg_limit) : (toc_beats >= avg_limit)) return;
        idx = wr_ptr - back[15:0];
        for (int k = 0; k < len; k++) begin
            if (is_tic) tic_sum[k] = tic_sum[k] + 23'(ring[idx]);
            else        toc_sum[k] = toc_sum[k] + 23'(ring[idx]);
            idx++;
        end
        if (is_tic) tic_beats++;
        else        toc_beats++;
    endtask

    task automatic scan_triggers(inout int done, inout int dropped);
        logic [31:0] need;
        logic [31:0] start;
        logic [31:0] back;
        need = (capture_len > 16'(avg_window)) ? 32'(capture_len) : 32'(avg_window);
        for (int i = trig_n - 1; i >= 0; i--) begin
            start = trig_pos[i] - 32'(pre_samples);
            back  = sample_count - start;
            if (back[31]) continue;
            if (back > fill_level) begin
                drop_trigger(i);
                dropped++;
                continue;
            end
            if (back < need) continue;
            add_epoch(trig_tic[i], back);
            drop_trigger(i);
            done++;
        end
    endtask

    task automatic predict_word();
        t_result     r;
        int          done;
        int          dropped;
        logic [16:0] mag;
        logic        cls;
        done    = 0;
        dropped = 0;
        r       = '0;
        case (t_req'(i_req_type))
            REQ_SAMPLE: begin
                mag = i_sample_value[15] ? 17'h10000 - 17'(i_sample_value)
                                         : 17'(i_sample_value);
                if (mag > 17'd32767) mag = 17'd32767;
                ring[wr_ptr] = mag[14:0];
                wr_ptr++;
                if (fill_level < 32'd65536) fill_level++;
                sample_count++;
                scan_triggers(done, dropped);
            end
            REQ_TRIGGER: begin
                cls    = i_has_class ? i_given_is_tic : (parity == 1'b0);
                parity = ~parity;
                if (trig_n >= 4) begin
                    drop_trigger(0);
                    dropped++;
                end
                trig_pos[trig_n] = i_event_pos;
                trig_tic[trig_n] = cls;
                trig_n++;
                scan_triggers(done, dropped);
            end
            REQ_READ: begin
                r.sum   = i_read_tic ? tic_sum[i_read_index] : toc_sum[i_read_index];
                r.count = i_read_tic ? tic_beats : toc_beats;
            end
            default: ;
        endcase
        r.done     = (done > 7) ? 3'd7 : 3'(done);
        r.dropped  = (dropped > 7) ? 3'd7 : 3'(dropped);
        r.complete = (tic_beats >= avg_limit) && (toc_beats >= avg_limit);
        result_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        t_result act_r;
        if (!i_rst_n) begin
            pre_samples  = PRE_RESET;
            capture_len  = CAPTURE_RESET;
            avg_window   = WINDOW_RESET;
            avg_limit    = LIMIT_RESET;
            wr_ptr       = '0;
            fill_level   = '0;
            sample_count = '0;
            trig_n       = 0;
            parity       = 1'b0;
            clear_sums();
            result_q.delete();
        end else begin
            if (o_valid && i_ready) begin
                act_r = '{o_avg_sum, o_avg_count, o_beats_done, o_beats_dropped,
                          o_cycle_complete};
                if (result_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result word: %p", act_r);
                    mismatches++;
                    o_fail_count++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (act_r !== exp_r) begin
                        if (mismatches < 10)
                            $display("mismatch: expected %p, got %p", exp_r, act_r);
                        mismatches++;
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && o_ready) predict_word();
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRE_SAMPLES: pre_samples = i_cfg_data[11:0];
                    CFG_CAPTURE_LEN: capture_len = i_cfg_data[15:0];
                    CFG_AVG_WINDOW: begin
                        avg_window = i_cfg_data[10:0];
                        clear_sums();
                    end
                    CFG_AVG_LIMIT:   avg_limit = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        o_outstanding = result_q.size();
    end

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        mismatches    = 0;
    end

endmodule

@@ tb/triggered_epoch_averager_tb.sv @@
// ----------------------------------------------------------------------------
// triggered_epoch_averager_tb
// Drives samples, triggers, reads and no-op words into the averager across
// several register settings, with random gaps and receiver stalls, and
// reports the verdict from the checker's failure and outstanding counts.
// ----------------------------------------------------------------------------
module triggered_epoch_averager_tb;
    import tea_pkg::*;

    localparam int          CYCLE_LIMIT = 2000000;
    localparam logic [3:0]  CFG_UNUSED  = 4'd15;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_req_type;
    logic [15:0] i_sample_value;
    logic [31:0] i_event_pos;
    logic        i_has_class;
    logic        i_given_is_tic;
    logic [9:0]  i_read_index;
    logic        i_read_tic;
    logic        o_valid;
    logic        i_ready;
    logic [22:0] o_avg_sum;
    logic [7:0]  o_avg_count;
    logic [2:0]  o_beats_done;
    logic [2:0]  o_beats_dropped;
    logic        o_cycle_complete;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    int          fail_count;
    int          outstanding;
    int          cycles;
    int          rx_hold;
    bit          quiet;
    logic [31:0] samples_sent;
    logic [11:0] cur_pre;
    logic [31:0] cur_need;
    logic [10:0] cur_window;

    triggered_epoch_averager DUT (.*);

    tea_checker u_checker (
        .*,
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[triggered_epoch_averager] ERROR");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
            end
            @(posedge i_clk);
            if (o_valid && i_ready) stall = quiet ? 0 : $urandom_range(0, 7);
        end
    end

    task automatic send_word(input t_req rt, input logic [15:0] sv,
                             input logic [31:0] pos, input logic hc, input logic gt,
                             input logic [9:0] ri, input logic rtic);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= rt;
        i_sample_value <= sv;
        i_event_pos    <= pos;
        i_has_class    <= hc;
        i_given_is_tic <= gt;
        i_read_index   <= ri;
        i_read_tic     <= rtic;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        if (rt == REQ_SAMPLE) samples_sent++;
    endtask

    task automatic send_sample(input logic [15:0] sv);
        send_word(REQ_SAMPLE, sv, $urandom, 1'($urandom), 1'($urandom), 10'($urandom),
                  1'($urandom));
    endtask

    task automatic send_trigger(input logic [31:0] pos, input logic hc, input logic gt);
        send_word(REQ_TRIGGER, 16'($urandom), pos, hc, gt, 10'($urandom), 1'($urandom));
    endtask

    task automatic send_read(input logic [9:0] ri, input logic rtic);
        send_word(REQ_READ, 16'($urandom), $urandom, 1'($urandom), 1'($urandom), ri, rtic);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [11:0] pre, input logic [15:0] cap,
                            input logic [10:0] win, input logic [7:0] lim);
        drain();
        repeat (8) @(negedge i_clk);
        write_reg(CFG_PRE_SAMPLES, 32'(pre));
        write_reg(CFG_CAPTURE_LEN, {16'($urandom_range(0, 65535)), cap});
        write_reg(CFG_AVG_WINDOW, 32'(win));
        write_reg(CFG_AVG_LIMIT, 32'(lim));
        cur_pre    = pre;
        cur_window = win;
        cur_need   = (32'(cap) > 32'(win)) ? 32'(cap) : 32'(win);
    endtask

    task automatic random_words(input int count);
        int          pick;
        int          span;
        int          rd_top;
        logic [31:0] pos;
        span   = (cur_need > 2000) ? 2000 : int'(cur_need);
        rd_top = (cur_window > 11'd1023) ? 1023 : int'(cur_window);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 58) begin
                send_sample(16'($urandom));
            end else if (pick < 83) begin
                pos = samples_sent + 32'(cur_pre) + 8 - $urandom_range(0, span + span / 2 + 40);
                send_trigger(pos, 1'($urandom), 1'($urandom));
            end else if (pick < 95) begin
                if ($urandom_range(0, 9) < 7)
                    send_read(10'($urandom_range(0, rd_top)), 1'($urandom));
                else
                    send_read(10'($urandom), 1'($urandom));
            end else if (pick < 98) begin
                send_trigger($urandom, 1'($urandom), 1'($urandom));
            end else begin
                send_word(REQ_NONE, 16'($urandom), $urandom, 1'($urandom), 1'($urandom),
                          10'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        cycles         = 0;
        rx_hold        = 0;
        quiet          = 1'b0;
        samples_sent   = '0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_req_type     = REQ_NONE;
        i_sample_value = '0;
        i_event_pos    = '0;
        i_has_class    = 1'b0;
        i_given_is_tic = 1'b0;
        i_read_index   = '0;
        i_read_tic     = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_PRE_SAMPLES;
        i_cfg_data     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, overflow, far-ahead and stale triggers
        set_regs(12'd4, 16'd1, 11'd1, 8'd1);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_trigger(32'd5, 1'b0, 1'b0);
        send_trigger(32'd6, 1'b0, 1'b1);
        send_trigger(32'd0, 1'b1, 1'b1);
        send_trigger(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_trigger(32'h8000_0000, 1'b1, 1'b1);
        send_trigger(32'h7FFF_FFF0, 1'b0, 1'b0);
        send_trigger(32'd12, 1'b1, 1'b0);
        send_trigger(32'd13, 1'b1, 1'b1);
        send_trigger(32'd14, 1'b0, 1'b0);
        send_sample(16'h4321);
        send_sample(16'hBCDE);
        send_read(10'd0, 1'b1);
        send_read(10'd0, 1'b0);
        send_read(10'd1023, 1'b1);
        send_read(10'd1023, 1'b0);
        send_word(REQ_NONE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 10'h3FF, 1'b1);

        set_regs(12'd16, 16'd24, 11'd16, 8'd255);
        random_words(80);

        set_regs(12'd0, 16'd8, 11'd32, 8'd3);
        quiet = 1'b1;
        random_words(60);
        quiet = 1'b0;

        set_regs(12'd100, 16'd40, 11'd20, 8'd4);
        rx_hold = 400;
        random_words(40);
        drain();
        random_words(40);

        set_regs(12'd4095, 16'd32768, 11'd1024, 8'd255);
        random_words(30);

        set_regs(12'd0, 16'd1, 11'd192, 8'd2);
        quiet = 1'b1;
        repeat (200) send_sample(16'($urandom));
        quiet = 1'b0;
        random_words(30);
        for (int k = 0; k < 4; k++) send_read(10'($urandom_range(0, 1023)), k[0]);

        drain();
        repeat (50) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[triggered_epoch_averager] OK");
        end else begin
            $display("[triggered_epoch_averager] ERROR");
        end
        $finish;
    end

endmodule
